### design/assert_macros.svh
// Assertion helpers used by sensor_readout_crc8_target.sv.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### design/sct_pkg.sv
`timescale 1ns / 1ps
package sct_pkg;

  localparam logic [7:0] CMD_MEASURE = 8'hFD;
  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam int         BUF_LEN     = 6;
  localparam int         PTR_W       = 3;

  localparam logic [PTR_W-1:0] PTR_EMPTY = PTR_W'(BUF_LEN);

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef struct packed {
    logic [15:0] humidity_ticks;
    logic [15:0] temperature_ticks;
    logic [7:0]  write_byte;
    mode_t       mode;
  } item_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] read_byte;
  } result_t;

endpackage

### design/sct_crc.sv
`timescale 1ns / 1ps
module sct_crc (
  input  logic [15:0] word,
  output logic [7:0]  crc
);
  import sct_pkg::*;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
    logic [7:0] c;
    c = c_in ^ d;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign crc = crc8_byte(crc8_byte(CRC_INIT, word[15:8]), word[7:0]);

endmodule

### design/sct_core.sv
`timescale 1ns / 1ps
module sct_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  sct_pkg::item_t   item,
  output sct_pkg::result_t result
);
  import sct_pkg::*;

  logic [7:0]       reading_buffer [BUF_LEN];
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] read_pointer_next;
  logic [7:0]       temp_crc;
  logic [7:0]       hum_crc;
  logic             measure;
  logic             pending;

  sct_crc u_temp_crc (
    .word (item.temperature_ticks),
    .crc  (temp_crc)
  );

  sct_crc u_hum_crc (
    .word (item.humidity_ticks),
    .crc  (hum_crc)
  );

  assign measure = (item.mode == MODE_WRITE) && (item.write_byte == CMD_MEASURE);
  assign pending = (read_pointer < PTR_EMPTY);

  always_comb begin
    read_pointer_next = read_pointer;
    result.ack        = 1'b1;
    result.read_byte  = 8'd0;
    if (measure) begin
      read_pointer_next = '0;
    end else if (item.mode == MODE_READ && pending) begin
      result.read_byte  = reading_buffer[read_pointer];
      read_pointer_next = read_pointer + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer <= PTR_EMPTY;
    end else if (advance) begin
      read_pointer <= read_pointer_next;
    end
  end

  // Temperature occupies the first three bytes, humidity the last three.
  always_ff @(posedge clk) begin
    if (advance && measure) begin
      reading_buffer[0] <= item.temperature_ticks[15:8];
      reading_buffer[1] <= item.temperature_ticks[7:0];
      reading_buffer[2] <= temp_crc;
      reading_buffer[3] <= item.humidity_ticks[15:8];
      reading_buffer[4] <= item.humidity_ticks[7:0];
      reading_buffer[5] <= hum_crc;
    end
  end

endmodule

### design/sensor_readout_crc8_target.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Bus-byte target of a temperature/humidity sensor with CRC-8 protected data.
// Each transfer on the s_axis side is one bus access: tuser = 1 is a read of
// one byte, tuser = 0 a write of the command byte in tdata[7:0]. Writing 0xFD
// latches the temperature and humidity ticks carried in the same transfer,
// stores each as high byte, low byte and CRC-8 (poly 0x31, init 0xFF), and
// rewinds the read pointer. Reads then return those six bytes in order and
// 0 afterwards; writes return 0. Every access yields exactly one transfer on
// the m_axis side, with tuser (ack) always 1.
// The result passes through the input register and then the output register:
// the input register feeds the state update, which loads the output register.
// One transfer is accepted every cycle while m_axis_tready stays high; the
// pointer and buffer are updated in the same cycle as the output register.
// When m_axis_tready is low, the output register holds its result; the input
// register still takes one more transfer if empty, then s_axis_tready drops.
// Reset clears both valid flags and marks the buffer as empty, so reads
// before the first measure command return 0.
module sensor_readout_crc8_target (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // write_byte[7:0], temperature_ticks[23:8],
                                      // humidity_ticks[39:24]
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_byte
  output logic        m_axis_tuser    // ack
);
  import sct_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  logic    advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.mode              <= mode_t'(s_axis_tuser);
      in_item.write_byte        <= s_axis_tdata[7:0];
      in_item.temperature_ticks <= s_axis_tdata[23:8];
      in_item.humidity_ticks    <= s_axis_tdata[39:24];
    end
  end

  sct_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.read_byte;
  assign m_axis_tuser  = out_result.ack;

  `ASSERT_NEXT(a_in_held, clk, rst, in_valid && !advance, in_valid,
               "input item lost while stalled")
  `ASSERT_NEXT(a_out_loaded, clk, rst, advance, m_axis_tvalid,
               "result missing after advance")
  `ASSERT_NEXT(a_write_zero, clk, rst, advance && in_item.mode == MODE_WRITE,
               m_axis_tdata == 8'd0, "write returned nonzero byte")
  `ASSERT_IMPLIES(a_no_drop, clk, rst, out_valid && !m_axis_tready, !advance,
                  "result overwritten while stalled")

endmodule

### bench/tb_sensor_readout_crc8_target.sv
`timescale 1ns / 1ps
module tb_sensor_readout_crc8_target;
  import sct_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned RANDOM_ACCESSES = 1700;
  localparam int unsigned REPORT_LIMIT = 10;

  // Tracks the sensor's stored bytes and read pointer and queues the reply
  // that each accepted bus access must produce.
  class readout_tracker;
    logic [7:0] stored[BUF_LEN];
    logic [PTR_W-1:0] next_idx;
    result_t pending_replies[$];
    int unsigned failures;
    int unsigned reported;

    function new();
      next_idx = PTR_EMPTY;
      failures = 0;
      reported = 0;
    endfunction

    // CRC-8 over the high byte then the low byte, MSB first.
    function logic [7:0] crc8_word(logic [15:0] word);
      logic [7:0] c;
      c = CRC_INIT;
      for (int i = 15; i >= 0; i--) begin
        c = (c[7] ^ word[i]) ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
    endfunction

    function void note_access(mode_t m, logic [7:0] cmd, logic [15:0] t, logic [15:0] h);
      result_t r;
      r.ack = 1'b1;
      r.read_byte = 8'h00;
      if (m == MODE_WRITE) begin
        if (cmd == CMD_MEASURE) begin
          stored[0] = t[15:8];
          stored[1] = t[7:0];
          stored[2] = crc8_word(t);
          stored[3] = h[15:8];
          stored[4] = h[7:0];
          stored[5] = crc8_word(h);
          next_idx = '0;
        end
      end else if (next_idx < PTR_EMPTY) begin
        r.read_byte = stored[next_idx];
        next_idx = next_idx + 1'b1;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [7:0] read_byte, logic ack);
      result_t want;
      if (pending_replies.size() == 0) begin
        failures++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("unexpected reply: read_byte=%02h ack=%b", read_byte, ack);
        end
        return;
      end
      want = pending_replies.pop_front();
      if (read_byte !== want.read_byte || ack !== want.ack) begin
        failures++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("reply mismatch: expected read_byte=%02h ack=%b, got read_byte=%02h ack=%b",
                   want.read_byte, want.ack, read_byte, ack);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // write_byte, temperature_ticks, humidity_ticks
  logic s_axis_tuser = 1'b0;       // mode
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // read_byte
  logic m_axis_tuser;              // ack

  readout_tracker tracker;
  int unsigned tx_idle_pct = 22;
  int unsigned rx_idle_pct = 59;
  int unsigned idle_phase = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  int unsigned quiet_cycles = 0;

  sensor_readout_crc8_target dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] other_cmd();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == CMD_MEASURE) b = 8'($urandom);
    return b;
  endfunction

  task automatic send_access(mode_t m, logic [7:0] cmd, logic [15:0] t, logic [15:0] h);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {h, t, cmd};
    s_axis_tuser <= m;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_access(m, cmd, t, h);
  endtask

  // Reply side: checks each transfer and throttles tready. Once the last
  // phase starts, tready is held low long enough for the block to back up.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_reply(m_axis_tdata, m_axis_tuser);
      if (idle_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned reads;
    logic [7:0] cmd;
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reads before any measurement return zero; on a read the command byte
    // does not matter.
    send_access(MODE_READ, 8'h00, 16'h0000, 16'h0000);
    send_access(MODE_READ, CMD_MEASURE, 16'hFFFF, 16'hFFFF);
    // Other command bytes are acknowledged and change nothing.
    send_access(MODE_WRITE, 8'h00, 16'h1234, 16'h5678);
    send_access(MODE_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_access(MODE_WRITE, 8'hFE, 16'h0001, 16'h8000);
    send_access(MODE_WRITE, CMD_MEASURE, 16'h0000, 16'hFFFF);
    // Seven reads: all six bytes, then one past the end.
    repeat (7) send_access(MODE_READ, 8'hFF, 16'hAAAA, 16'h5555);
    send_access(MODE_WRITE, CMD_MEASURE, 16'hFFFF, 16'h0000);
    repeat (2) send_access(MODE_READ, 8'h00, 16'h5555, 16'hAAAA);
    send_access(MODE_WRITE, 8'hFC, 16'h0000, 16'h0000);
    // A new measurement in the middle of a readout restarts it.
    send_access(MODE_WRITE, CMD_MEASURE, 16'hBEEF, 16'h0080);
    repeat (7) send_access(MODE_READ, 8'h7E, 16'hFFFF, 16'h0000);

    sent = 0;
    while (sent < RANDOM_ACCESSES) begin
      if (sent >= 2 * RANDOM_ACCESSES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        idle_phase = 2;
      end else if (sent >= RANDOM_ACCESSES / 3) begin
        tx_idle_pct = 59;
        rx_idle_pct = 22;
        idle_phase = 1;
      end
      if ($urandom_range(99) < 75) begin
        // Measurement followed by a partial, full or overlong readout.
        send_access(MODE_WRITE, CMD_MEASURE, pick_ticks(), pick_ticks());
        reads = $urandom_range(8);
        sent += reads + 1;
        repeat (reads) begin
          if ($urandom_range(19) == 0) begin
            send_access(MODE_WRITE, other_cmd(), pick_ticks(), pick_ticks());
          end
          send_access(MODE_READ, 8'($urandom), pick_ticks(), pick_ticks());
        end
      end else begin
        cmd = ($urandom_range(7) == 0) ? CMD_MEASURE : 8'($urandom);
        send_access(mode_t'($urandom_range(1)), cmd, pick_ticks(), pick_ticks());
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/sct_pkg.sv
design/sct_crc.sv
design/sct_core.sv
design/sensor_readout_crc8_target.sv
bench/tb_sensor_readout_crc8_target.sv
